@@ hdl/uedf_pkg.sv @@
package uedf_pkg;

  // field widths
  localparam int unsigned ChW     = 2;
  localparam int unsigned OvfW    = 6;
  localparam int unsigned CntW    = 16;
  localparam int unsigned TotalW  = OvfW + CntW;   // overflow:count ticks
  localparam int unsigned ProdW   = TotalW + 5;    // ticks * 17
  localparam int unsigned DistW   = 17;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ThouW   = 7;             // distance / 1000, up to 71
  localparam int unsigned DigW    = 4;

  // reciprocal of 1000 for the ticks * 17 product, exact below 2^27
  localparam int unsigned DistRecipW  = 28;
  localparam logic [DistRecipW-1:0] DistRecip = 28'd137438954;
  localparam int unsigned DistShift   = 37;
  localparam int unsigned DistMulW    = ProdW + DistRecipW;

  // reciprocal of 1000 for a distance, exact below 2^17
  localparam int unsigned ThRecipW    = 18;
  localparam logic [ThRecipW-1:0] ThRecip = 18'd134218;
  localparam int unsigned ThShift     = 27;
  localparam int unsigned ThMulW      = DistW + ThRecipW;

  // reciprocal of 100 for a remainder below 1000
  localparam int unsigned Rem1W       = 10;
  localparam logic [5:0] HuRecip      = 6'd41;
  localparam int unsigned HuShift     = 12;
  localparam int unsigned HuMulW      = 16;

  // reciprocal of 10 for a remainder below 100
  localparam int unsigned Rem2W       = 7;
  localparam logic [7:0] TeRecip      = 8'd205;
  localparam int unsigned TeShift     = 11;
  localparam int unsigned TeMulW      = 15;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegHeader  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTrailer = 1'b1;

  localparam logic [ByteW-1:0] HeaderReset  = 8'h0b;
  localparam logic [ByteW-1:0] TrailerReset = 8'h0d;

  // decimal digits of one channel distance
  typedef struct packed {
    logic [ThouW-1:0] thou;
    logic [DigW-1:0]  hund;
    logic [DigW-1:0]  tens;
    logic [DigW-1:0]  ones;
  } digits_t;

endpackage

@@ hdl/uedf_cap_if.sv @@
interface uedf_cap_if;
  logic                           valid;
  logic                           ready;
  logic [uedf_pkg::ChW-1:0]       channel;
  logic [uedf_pkg::OvfW-1:0]      overflow_count;
  logic [uedf_pkg::CntW-1:0]      capture_count;

  modport source (output valid, channel, overflow_count, capture_count, input ready);
  modport sink   (input valid, channel, overflow_count, capture_count, output ready);
endinterface

@@ hdl/uedf_frm_if.sv @@
interface uedf_frm_if;
  logic                         valid;
  logic                         ready;
  logic [uedf_pkg::ByteW-1:0]   frame_byte;
  logic                         last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

@@ hdl/uedf_dist.sv @@
module uedf_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [uedf_pkg::ChW-1:0]      ch_i,
  input  logic [uedf_pkg::OvfW-1:0]     ovf_i,
  input  logic [uedf_pkg::CntW-1:0]     cnt_i,
  output logic                          valid_o,
  output logic [uedf_pkg::ChW-1:0]      ch_o,
  output uedf_pkg::digits_t             dig_o
);

  // stage valids and channel tags
  logic [4:0] vld_q, vld_d;
  logic [uedf_pkg::ChW-1:0] ch1_q, ch2_q, ch3_q, ch4_q, ch5_q;

  // stage payloads
  logic [uedf_pkg::TotalW-1:0] total_q;
  logic [uedf_pkg::DistW-1:0]  dist2_q, dist3_q;
  logic [uedf_pkg::ThouW-1:0]  thou3_q, thou4_q;
  logic [uedf_pkg::DigW-1:0]   hund4_q;
  logic [uedf_pkg::Rem1W-1:0]  rem4_q;
  uedf_pkg::digits_t           dig5_q;

  logic [uedf_pkg::ProdW-1:0]    prod;
  logic [uedf_pkg::DistMulW-1:0] dist_mul;
  logic [uedf_pkg::DistW-1:0]    dist_d;
  logic [uedf_pkg::ThMulW-1:0]   th_mul;
  logic [uedf_pkg::DistW-1:0]    rem1_full;
  logic [uedf_pkg::Rem1W-1:0]    rem1;
  logic [uedf_pkg::HuMulW-1:0]   hu_mul;
  logic [uedf_pkg::Rem1W-1:0]    rem2_full;
  logic [uedf_pkg::Rem2W-1:0]    rem2;
  logic [uedf_pkg::TeMulW-1:0]   te_mul;
  logic [uedf_pkg::DigW-1:0]     tens;
  logic [uedf_pkg::Rem2W-1:0]    ones_full;

  // ticks * 17 then divide by 1000
  assign prod     = uedf_pkg::ProdW'(total_q) + (uedf_pkg::ProdW'(total_q) << 4);
  assign dist_mul = uedf_pkg::DistMulW'(prod) * uedf_pkg::DistMulW'(uedf_pkg::DistRecip);
  assign dist_d   = dist_mul[uedf_pkg::DistShift +: uedf_pkg::DistW];

  // thousands
  assign th_mul = uedf_pkg::ThMulW'(dist2_q) * uedf_pkg::ThMulW'(uedf_pkg::ThRecip);

  // hundreds
  assign rem1_full = dist3_q - (uedf_pkg::DistW'(thou3_q) * uedf_pkg::DistW'(1000));
  assign rem1      = rem1_full[uedf_pkg::Rem1W-1:0];
  assign hu_mul    = uedf_pkg::HuMulW'(rem1) * uedf_pkg::HuMulW'(uedf_pkg::HuRecip);

  // tens and ones
  assign rem2_full = rem4_q - (uedf_pkg::Rem1W'(hund4_q) * uedf_pkg::Rem1W'(100));
  assign rem2      = rem2_full[uedf_pkg::Rem2W-1:0];
  assign te_mul    = uedf_pkg::TeMulW'(rem2) * uedf_pkg::TeMulW'(uedf_pkg::TeRecip);
  assign tens      = te_mul[uedf_pkg::TeShift +: uedf_pkg::DigW];
  assign ones_full = rem2 - (uedf_pkg::Rem2W'(tens) * uedf_pkg::Rem2W'(10));

  assign vld_d = {vld_q[3:0], valid_i};

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_d;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ch1_q   <= ch_i;
      total_q <= {ovf_i, cnt_i};
      ch2_q   <= ch1_q;
      dist2_q <= dist_d;
      ch3_q   <= ch2_q;
      dist3_q <= dist2_q;
      thou3_q <= th_mul[uedf_pkg::ThShift +: uedf_pkg::ThouW];
      ch4_q   <= ch3_q;
      thou4_q <= thou3_q;
      hund4_q <= hu_mul[uedf_pkg::HuShift +: uedf_pkg::DigW];
      rem4_q  <= rem1;
      ch5_q   <= ch4_q;
      dig5_q.thou <= thou4_q;
      dig5_q.hund <= hund4_q;
      dig5_q.tens <= tens;
      dig5_q.ones <= ones_full[uedf_pkg::DigW-1:0];
    end
  end

  assign valid_o = vld_q[4];
  assign ch_o    = ch5_q;
  assign dig_o   = dig5_q;

endmodule

@@ hdl/uedf_emit.sv @@
module uedf_emit #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  uedf_pkg::digits_t           snap_i [NUM_CHANNELS],
  input  logic [uedf_pkg::ByteW-1:0]  header_i,
  input  logic [uedf_pkg::ByteW-1:0]  trailer_i,
  output logic                        busy_o,
  uedf_frm_if.source                  frame
);

  localparam int unsigned FrameLen = 2 + 4 * NUM_CHANNELS;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam int unsigned SelW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameLen - 1);

  logic                        busy_q;
  logic [IdxW-1:0]             idx_q;
  uedf_pkg::digits_t           snap_q [NUM_CHANNELS];
  logic                        out_vld_q;
  logic [uedf_pkg::ByteW-1:0]  out_byte_q, out_byte_d;
  logic                        out_last_q;

  logic                        out_free;
  logic [IdxW-1:0]             dig_idx;
  logic [SelW-1:0]             sel_ch;
  uedf_pkg::digits_t           sel_dig;

  assign out_free = !out_vld_q || frame.ready;

  // byte select: header, four digits per channel, trailer
  assign dig_idx = idx_q - IdxW'(1);
  assign sel_ch  = SelW'(dig_idx >> 2);
  assign sel_dig = snap_q[sel_ch];

  always_comb begin
    if (idx_q == '0) begin
      out_byte_d = header_i;
    end else if (idx_q == LastIdx) begin
      out_byte_d = trailer_i;
    end else begin
      case (dig_idx[1:0])
        2'd0:    out_byte_d = uedf_pkg::ByteW'(sel_dig.thou);
        2'd1:    out_byte_d = uedf_pkg::ByteW'(sel_dig.hund);
        2'd2:    out_byte_d = uedf_pkg::ByteW'(sel_dig.tens);
        default: out_byte_d = uedf_pkg::ByteW'(sel_dig.ones);
      endcase
    end
  end

  // sequencer and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= busy_q;
      end
      if (load_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q && out_free) begin
        idx_q <= idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // frame snapshot and output payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
    if (out_free && busy_q) begin
      out_byte_q <= out_byte_d;
      out_last_q <= (idx_q == LastIdx);
    end
  end

  assign busy_o           = busy_q;
  assign frame.valid      = out_vld_q;
  assign frame.frame_byte = out_byte_q;
  assign frame.last_byte  = out_last_q;

endmodule

@@ hdl/ultrasonic_echo_distance_framer_unit.sv @@
// Echo distance framer. Each capture transfer (channel, overflow_count, capture_count) is
// turned into a distance floor((overflow_count*65536 + capture_count) * 17 / 1000) and its
// four decimal digits by a five-stage register pipeline that takes one capture per cycle
// while it is not stalled; the digits then land in the channel's slot. Captures on a
// channel at or above NUM_CHANNELS are taken and dropped. When every channel has a fresh
// value the fresh marks clear and a frame of 2 + 4*NUM_CHANNELS bytes (header, then
// thousands, hundreds, tens and ones per channel, then trailer with last_byte set) is
// snapshotted and sent from an output register at one byte per cycle while the receiver
// is ready. The frame sender holds one frame at a time: a capture that completes a frame
// while the previous one is still being sent stalls the capture pipeline until it frees.
// A new frame loads only after the previous trailer is issued. Header and trailer come
// from the two configuration registers (index 0 and 1) and must only be written while idle.
module ultrasonic_echo_distance_framer_unit #(
  parameter int unsigned NUM_CHANNELS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [uedf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [uedf_pkg::ByteW-1:0]      cfg_data_i,
  uedf_cap_if.sink                        capture,
  uedf_frm_if.source                      frame
);

  logic [uedf_pkg::ByteW-1:0] header_q, trailer_q;
  logic [NUM_CHANNELS-1:0]    fresh_q, fresh_nx;
  uedf_pkg::digits_t          store_q [NUM_CHANNELS];
  uedf_pkg::digits_t          snap    [NUM_CHANNELS];

  logic                       adv;
  logic                       ch_ok;
  logic                       s5_vld;
  logic [uedf_pkg::ChW-1:0]   s5_ch;
  uedf_pkg::digits_t          s5_dig;
  logic                       complete;
  logic                       emit_busy;
  logic                       emit_load;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= uedf_pkg::HeaderReset;
      trailer_q <= uedf_pkg::TrailerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uedf_pkg::RegHeader:  header_q  <= cfg_data_i;
        uedf_pkg::RegTrailer: trailer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // capture intake, out of range channels are dropped
  assign ch_ok         = (int'(capture.channel) < int'(NUM_CHANNELS));
  assign capture.ready = adv;

  uedf_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (capture.valid && ch_ok),
    .ch_i    (capture.channel),
    .ovf_i   (capture.overflow_count),
    .cnt_i   (capture.capture_count),
    .valid_o (s5_vld),
    .ch_o    (s5_ch),
    .dig_o   (s5_dig)
  );

  // fresh marks after the pipeline result and the frame snapshot
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      fresh_nx[c] = fresh_q[c] || (int'(s5_ch) == c);
      snap[c]     = (int'(s5_ch) == c) ? s5_dig : store_q[c];
    end
  end

  assign complete  = s5_vld && (&fresh_nx);
  assign adv       = !(complete && emit_busy);
  assign emit_load = complete && !emit_busy;

  // fresh marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= '0;
    end else if (adv && s5_vld) begin
      fresh_q <= complete ? '0 : fresh_nx;
    end
  end

  // per-channel digit store
  always_ff @(posedge clk_i) begin
    if (adv && s5_vld) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (int'(s5_ch) == c) begin
          store_q[c] <= s5_dig;
        end
      end
    end
  end

  uedf_emit #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_emit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit_load),
    .snap_i    (snap),
    .header_i  (header_q),
    .trailer_i (trailer_q),
    .busy_o    (emit_busy),
    .frame     (frame)
  );

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumCh        = 3;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned RandItems    = 300;
  localparam int unsigned CalmItems    = 60;
  localparam logic [uedf_pkg::ChW-1:0] BadChannel = 2'd3;

  typedef struct packed {
    logic [uedf_pkg::ByteW-1:0] data;
    logic                       last;
  } frame_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [uedf_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [uedf_pkg::ByteW-1:0] cfg_data_i;

  uedf_cap_if cap_if();
  uedf_frm_if frm_if();

  ultrasonic_echo_distance_framer_unit #(
    .NUM_CHANNELS(NumCh)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .capture    (cap_if),
    .frame      (frm_if)
  );

  // predictor state: stored distances, fresh marks, header and trailer
  logic [uedf_pkg::DistW-1:0] dist_cm [NumCh];
  logic [NumCh-1:0]           fresh_marks;
  logic [uedf_pkg::ByteW-1:0] header_val;
  logic [uedf_pkg::ByteW-1:0] trailer_val;
  frame_beat_t                frame_beats_q[$];

  int unsigned errors;
  int unsigned cycles;
  bit          calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d frame bytes outstanding", $time, frame_beats_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls in random bursts, none once calm
  initial begin : frame_ready_gen
    int unsigned burst;
    bit          hold;
    burst = 0;
    hold  = 1'b0;
    frm_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        frm_if.ready <= 1'b1;
      end else begin
        if (burst == 0) begin
          hold  = ($urandom_range(0, 2) == 0);
          burst = $urandom_range(1, 17);
        end
        burst = burst - 1;
        frm_if.ready <= !hold;
      end
    end
  end

  function automatic void push_beat(logic [uedf_pkg::ByteW-1:0] data, logic last);
    frame_beat_t beat;
    beat.data = data;
    beat.last = last;
    frame_beats_q.push_back(beat);
  endfunction

  // distance = floor((ovf*65536 + cnt) * 17 / 1000); frame once all channels are fresh
  function automatic void predict_capture(logic [uedf_pkg::ChW-1:0] ch,
                                          logic [uedf_pkg::OvfW-1:0] ovf,
                                          logic [uedf_pkg::CntW-1:0] cnt);
    int unsigned ticks;
    int unsigned d;
    if (ch >= NumCh) return;
    ticks = {ovf, cnt};
    d = (ticks * 17) / 1000;
    dist_cm[ch] = d[uedf_pkg::DistW-1:0];
    fresh_marks[ch] = 1'b1;
    if (!(&fresh_marks)) return;
    fresh_marks = '0;
    push_beat(header_val, 1'b0);
    for (int c = 0; c < NumCh; c++) begin
      d = dist_cm[c];
      push_beat(uedf_pkg::ByteW'(d / 1000), 1'b0);
      push_beat(uedf_pkg::ByteW'((d % 1000) / 100), 1'b0);
      push_beat(uedf_pkg::ByteW'((d % 100) / 10), 1'b0);
      push_beat(uedf_pkg::ByteW'(d % 10), 1'b0);
    end
    push_beat(trailer_val, 1'b1);
  endfunction

  // compare every frame byte transfer with the oldest prediction
  always @(posedge clk_i) begin : frame_check
    frame_beat_t want;
    if (rst_ni && frm_if.valid && frm_if.ready) begin
      if (frame_beats_q.size() == 0) begin
        $display("%0t: unexpected frame byte, expected none, actual %0d last %0b",
                 $time, frm_if.frame_byte, frm_if.last_byte);
        errors++;
      end else begin
        want = frame_beats_q.pop_front();
        if (frm_if.frame_byte !== want.data) begin
          $display("%0t: frame_byte mismatch, expected %0d, actual %0d",
                   $time, want.data, frm_if.frame_byte);
          errors++;
        end
        if (frm_if.last_byte !== want.last) begin
          $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                   $time, want.last, frm_if.last_byte);
          errors++;
        end
      end
    end
  end

  // one capture transfer, with an optional idle burst ahead of it
  task automatic send_capture(logic [uedf_pkg::ChW-1:0] ch, logic [uedf_pkg::OvfW-1:0] ovf,
                              logic [uedf_pkg::CntW-1:0] cnt);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      cap_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cap_if.valid          <= 1'b1;
    cap_if.channel        <= ch;
    cap_if.overflow_count <= ovf;
    cap_if.capture_count  <= cnt;
    do @(posedge clk_i); while (cap_if.ready !== 1'b1);
    predict_capture(ch, ovf, cnt);
  endtask

  // sender pauses until every predicted byte has come, then lets the pipeline settle
  task automatic wait_frames_drained();
    @(negedge clk_i);
    cap_if.valid <= 1'b0;
    while (frame_beats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [uedf_pkg::CfgIdxW-1:0] idx,
                           logic [uedf_pkg::ByteW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == uedf_pkg::RegHeader) header_val = data;
    else trailer_val = data;
  endtask

  task automatic set_frame_marks(logic [uedf_pkg::ByteW-1:0] hdr,
                                 logic [uedf_pkg::ByteW-1:0] trl);
    wait_frames_drained();
    write_reg(uedf_pkg::RegHeader, hdr);
    write_reg(uedf_pkg::RegTrailer, trl);
  endtask

  // reset values of header and trailer, zero and full-scale distances
  task automatic test_reset_marks();
    send_capture(2'd0, 6'd0, 16'd0);
    send_capture(2'd1, 6'd63, 16'hffff);
    send_capture(2'd2, 6'd0, 16'd58765);
    wait_frames_drained();
  endtask

  // captures on an unused channel change nothing
  task automatic test_unused_channel();
    send_capture(BadChannel, 6'd63, 16'hffff);
    send_capture(2'd2, 6'd1, 16'd2);
    send_capture(BadChannel, 6'd0, 16'd0);
    send_capture(2'd0, 6'd0, 16'd58824);
    send_capture(2'd1, 6'd32, 16'h8000);
    wait_frames_drained();
  endtask

  // a capture on an already fresh channel overwrites its distance
  task automatic test_repeat_capture();
    send_capture(2'd0, 6'd5, 16'd100);
    send_capture(2'd0, 6'd63, 16'd0);
    send_capture(2'd1, 6'd0, 16'd1);
    send_capture(2'd1, 6'd0, 16'd59);
    send_capture(2'd2, 6'd0, 16'hffff);
    wait_frames_drained();
  endtask

  // header and trailer at their extremes
  task automatic test_mark_extremes();
    set_frame_marks(8'h00, 8'hff);
    send_capture(2'd2, 6'd63, 16'hffff);
    send_capture(2'd1, 6'd0, 16'd0);
    send_capture(2'd0, 6'd21, 16'h5555);
    set_frame_marks(8'hff, 8'h00);
    send_capture(2'd1, 6'd42, 16'haaaa);
    send_capture(2'd0, 6'd63, 16'hffff);
    send_capture(2'd2, 6'd0, 16'd999);
    wait_frames_drained();
  endtask

  function automatic logic [uedf_pkg::OvfW-1:0] rand_overflow();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return uedf_pkg::OvfW'($urandom);
    endcase
  endfunction

  function automatic logic [uedf_pkg::CntW-1:0] rand_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return uedf_pkg::CntW'($urandom);
    endcase
  endfunction

  // mostly complete rounds over all channels in random order, some stray captures
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned a;
    int unsigned b;
    logic [uedf_pkg::ChW-1:0] ch;
    sent = 0;
    while (sent < RandItems) begin
      if (sent + CalmItems >= RandItems) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        a = $urandom_range(0, 2);
        b = (a + 1 + $urandom_range(0, 1)) % 3;
        send_capture(uedf_pkg::ChW'(a), rand_overflow(), rand_count());
        send_capture(uedf_pkg::ChW'(b), rand_overflow(), rand_count());
        send_capture(uedf_pkg::ChW'(3 - a - b), rand_overflow(), rand_count());
        sent += 3;
      end else begin
        ch = uedf_pkg::ChW'($urandom_range(0, 3));
        send_capture(ch, rand_overflow(), rand_count());
        if (ch < NumCh) sent++;
      end
      if (!calm && $urandom_range(0, 19) == 0) wait_frames_drained();
      if (!calm && $urandom_range(0, 29) == 0) begin
        set_frame_marks(uedf_pkg::ByteW'($urandom), uedf_pkg::ByteW'($urandom));
      end
    end
    wait_frames_drained();
  endtask

  initial begin
    errors      = 0;
    cycles      = 0;
    calm        = 1'b0;
    fresh_marks = '0;
    header_val  = uedf_pkg::HeaderReset;
    trailer_val = uedf_pkg::TrailerReset;
    for (int c = 0; c < NumCh; c++) dist_cm[c] = '0;
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_idx_i             = uedf_pkg::RegHeader;
    cfg_data_i            = '0;
    cap_if.valid          = 1'b0;
    cap_if.channel        = '0;
    cap_if.overflow_count = '0;
    cap_if.capture_count  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_marks();
    test_unused_channel();
    test_repeat_capture();
    test_mark_extremes();
    set_frame_marks(uedf_pkg::HeaderReset, uedf_pkg::TrailerReset);
    test_random_traffic();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
